FILE: hdl/plx_pkg.sv
// Shared constants, codes and types of the positional list engine.
package plx_pkg;

   localparam int CAPACITY = 64;
   localparam int VAL_W    = 32;
   localparam int POS_W    = 7;
   localparam int COUNT_W  = 7;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_READ   = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MODE_HOLD,
      MODE_INSERT,
      MODE_REMOVE
   } mode_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      mode_type          mode;
      logic [CMP_W-1:0]  idx;
      logic [VAL_W-1:0]  value;
   } cell_cmd_type;

endpackage

FILE: hdl/plx_req_if.sv
// Request channel: operation, position and value with a valid/ready handshake.
interface plx_req_if
   import plx_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               op;
   logic [POS_W-1:0]         position;
   logic signed [VAL_W-1:0]  value;

   modport source (output valid, op, position, value, input ready);
   modport sink   (input valid, op, position, value, output ready);
endinterface

FILE: hdl/plx_rsp_if.sv
// Response channel: data, status, count and empty flag with a valid/ready handshake.
interface plx_rsp_if
   import plx_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [VAL_W-1:0]  data;
   logic [1:0]               status;
   logic [COUNT_W-1:0]       count;
   logic                     is_empty;

   modport source (output valid, data, status, count, is_empty, input ready);
   modport sink   (input valid, data, status, count, is_empty, output ready);
endinterface

FILE: hdl/positional_list_engine_core.sv
// Top level of the positional list engine: cell chain, count and response register.
//
//   channel | dir | handshake          | payload
//   req_    | in  | req_link.valid/rdy | op, position, value
//   rsp_    | out | rsp_link.valid/rdy | data, status, count, is_empty
//
// All cells shift in parallel in the cycle a request is accepted, and
// the response is registered at that edge.
// A new request is taken every cycle while the response register is empty
// or being drained; a stalled response holds the next request back.
// Synchronous reset empties the list; entries keep no reset value.
module positional_list_engine_core
   import plx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   plx_req_if.sink      req_link,
   plx_rsp_if.source    rsp_link
);

   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]          rsp_data_ff, rsp_data_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                      rsp_empty_ff, rsp_empty_in;

   logic                      accept;
   logic [CMP_W-1:0]          k_ext, c_ext;
   logic                      pos_ok_ins, pos_ok_rd, full;
   cell_cmd_type              cmd;
   logic [VAL_W-1:0]          entries  [CAPACITY];
   logic [VAL_W-1:0]          hits     [CAPACITY];
   logic [VAL_W-1:0]          read_val;

   // Hold requests off while in reset.
   assign req_link.ready = !reset && (!rsp_valid_ff || rsp_link.ready);
   assign accept         = req_link.valid && req_link.ready;

   assign k_ext      = CMP_W'(req_link.position);
   assign c_ext      = CMP_W'(cnt_ff);
   assign pos_ok_ins = (k_ext != '0) && (k_ext <= c_ext + CMP_W'(1));
   assign pos_ok_rd  = (k_ext != '0) && (k_ext <= c_ext);
   assign full       = (c_ext == CMP_W'(CAPACITY));

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [VAL_W-1:0] left_w, right_w;
         if (gi == 0) begin : g_first
            assign left_w = '0;
         end else begin : g_mid_l
            assign left_w = entries[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign right_w = '0;
         end else begin : g_mid_r
            assign right_w = entries[gi+1];
         end
         plx_cell u_cell (
            .clock       (clock),
            .cell_idx    (IDX_W'(gi)),
            .cmd         (cmd),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entries[gi]),
            .hit_data    (hits[gi])
         );
      end
   endgenerate

   // Only the addressed cell drives a nonzero word.
   always_comb begin
      read_val = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_val = read_val | hits[i];
      end
   end

   always_comb begin
      cmd.mode      = MODE_HOLD;
      cmd.idx       = k_ext - CMP_W'(1);
      cmd.value     = req_link.value;
      cnt_in        = cnt_ff;
      rsp_data_in   = '0;
      rsp_status_in = ST_OK;
      if (req_link.op == OP_INSERT) begin
         if (!pos_ok_ins) rsp_status_in = ST_BAD_POS;
         else if (full) rsp_status_in = ST_FULL;
         else if (accept) begin
            cmd.mode = MODE_INSERT;
            cnt_in   = cnt_ff + CNT_W'(1);
         end
      end else if (req_link.op == OP_READ || req_link.op == OP_REMOVE) begin
         if (!pos_ok_rd) rsp_status_in = ST_BAD_POS;
         else begin
            rsp_data_in = read_val;
            if (req_link.op == OP_REMOVE && accept) begin
               cmd.mode = MODE_REMOVE;
               cnt_in   = cnt_ff - CNT_W'(1);
            end
         end
      end else begin
         rsp_status_in = ST_BAD_POS;
      end
      rsp_count_in = COUNT_W'(cnt_in);
      rsp_empty_in = (cnt_in == '0);
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_link.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the response only when a request is taken.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_empty_ff  <= rsp_empty_in;
      end
   end

   assign rsp_link.valid    = rsp_valid_ff;
   assign rsp_link.data     = rsp_data_ff;
   assign rsp_link.status   = rsp_status_ff;
   assign rsp_link.count    = rsp_count_ff;
   assign rsp_link.is_empty = rsp_empty_ff;

endmodule

FILE: hdl/plx_cell.sv
// One list cell: holds an entry and takes it from itself, a neighbor or the request.
module plx_cell
   import plx_pkg::*;
(
   input  logic                clock,
   input  logic [IDX_W-1:0]    cell_idx,
   input  cell_cmd_type        cmd,
   input  logic [VAL_W-1:0]    left_entry,
   input  logic [VAL_W-1:0]    right_entry,
   output logic [VAL_W-1:0]    entry,
   output logic [VAL_W-1:0]    hit_data
);

   logic [VAL_W-1:0]  entry_ff;
   logic [VAL_W-1:0]  entry_in;
   logic [CMP_W-1:0]  me;

   assign me = CMP_W'(cell_idx);

   always_comb begin
      entry_in = entry_ff;
      case (cmd.mode)
         MODE_INSERT: begin
            if (me == cmd.idx) entry_in = cmd.value;
            else if (me > cmd.idx) entry_in = left_entry;
         end
         MODE_REMOVE: begin
            if (me >= cmd.idx) entry_in = right_entry;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry    = entry_ff;
   assign hit_data = (me == cmd.idx) ? entry_ff : '0;

endmodule
